/* design/fact_interning_hash_table_top_assert.svh */
// assertion macros for the fact interning table
`ifndef FACT_INTERNING_HASH_TABLE_TOP_ASSERT_SVH
`define FACT_INTERNING_HASH_TABLE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define FIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* design/fiht_pkg.sv */
// ----------------------------------------------------------------------------
// fiht_pkg
// shared types and codes of the fact interning table
// ----------------------------------------------------------------------------
package fiht_pkg;
    localparam int unsigned PRED_W   = 8;
    localparam int unsigned ARG_W    = 16;
    localparam int unsigned CNT_W    = 2;
    localparam int unsigned ID_OUT_W = 10;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned LIMIT_W  = 9;
    localparam int unsigned MAX_ARGS = 3;

    localparam logic [0:0] REG_PRED_LIMIT = 1'b0;

    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_LOOK,
        S_HEAD,
        S_FETCH,
        S_CMP,
        S_INSERT,
        S_OUT
    } t_state;
endpackage

/* design/fact_interning_hash_table_top.sv */
// ----------------------------------------------------------------------------
// fact_interning_hash_table_top
// interns ground facts under dense ids, with hashed bucket chains in memory
// ----------------------------------------------------------------------------
// One request at a time. The word is taken in the idle state, then the fact is
// hashed at one cycle per field (three plus arg_count fields), the bucket head
// is read (look and head states), each chain entry visited is fetched (fact and
// link memory read) and compared, the end of a chain is seen in a last fetch,
// an add with room then passes the insert state, and the response word is
// offered from the next cycle until it is taken. An invalid request goes from
// the first hash step straight to the response. The bucket head memory is
// cleared after reset by a pass over the buckets during which no word is
// taken. tuser in: kind. tdata in: predicate, negated, arg_count, arg_first,
// arg_second, arg_third. tdata out: fact_id. tuser out: status.
module fact_interning_hash_table_top #(
    parameter int unsigned MAX_FACTS = 1024,
    parameter int unsigned BUCKETS   = 1024,
    parameter int unsigned MAX_PREDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[0]
    input  logic        s_axis_tuser,
    // predicate[7:0], negated[8], arg_count[10:9],
    // arg_first[26:11], arg_second[42:27], arg_third[58:43]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fact_id[9:0]
    output logic [15:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser
);
    import fiht_pkg::*;

    localparam int unsigned ID_W   = $clog2(MAX_FACTS);
    localparam int unsigned TOT_W  = ID_W + 1;
    localparam int unsigned BKT_W  = $clog2(BUCKETS);
    localparam int unsigned FACT_W = PRED_W + 1 + CNT_W + 3 * ARG_W;
    localparam int unsigned LINK_W = ID_W + 1;
    localparam int unsigned CLR_W  = BKT_W + 1;

    t_state r_state, n_state;

    logic [LIMIT_W-1:0] r_limit;
    logic [TOT_W-1:0]   r_total;
    logic [CLR_W-1:0]   r_clr;
    logic               clearing;

    logic                r_kind, r_neg;
    logic [PRED_W-1:0]   r_pred;
    logic [CNT_W-1:0]    r_cnt;
    logic [ARG_W-1:0]    r_arg [3];
    logic [31:0]         r_hash;
    logic [2:0]          r_hstep;
    logic [LINK_W-1:0]   r_cur;
    logic [LINK_W-1:0]   r_head;
    logic [TOT_W-1:0]    r_steps;
    logic [ID_OUT_W-1:0] r_id;
    logic [STAT_W-1:0]   r_stat;

    logic [LINK_W-1:0] head_mem [BUCKETS];
    logic [FACT_W-1:0] fact_mem [MAX_FACTS];
    logic [LINK_W-1:0] link_mem [MAX_FACTS];
    logic [LINK_W-1:0] r_head_rd;
    logic [FACT_W-1:0] r_fact_rd;
    logic [LINK_W-1:0] r_link_rd;

    logic [BKT_W-1:0]  bkt;
    logic [FACT_W-1:0] q_fact;
    logic [31:0]       mix_v;
    logic [31:0]       limit_eff;
    logic              in_acc, invalid, same;

    assign pready        = 1'b1;
    assign prdata        = {{(32-LIMIT_W){1'b0}}, r_limit};
    assign clearing      = !r_clr[BKT_W];
    assign s_axis_tready = (r_state == S_IDLE) && !clearing;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {{(16-ID_OUT_W){1'b0}}, r_id};
    assign m_axis_tuser  = r_stat;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign bkt           = r_hash[BKT_W-1:0];

    // effective predicate bound and request check
    assign limit_eff = (32'(r_limit) < MAX_PREDS) ? 32'(r_limit) : MAX_PREDS;
    assign invalid   = (32'(r_pred) >= limit_eff) || (32'(r_cnt) > MAX_ARGS);

    // unused argument fields stored as zero
    always_comb begin
        q_fact = {r_arg[2], r_arg[1], r_arg[0], r_cnt, r_neg, r_pred};
        for (int k = 0; k < 3; k++) begin
            if (k >= int'(r_cnt) || k >= int'(MAX_ARGS)) begin
                q_fact[PRED_W+1+CNT_W+k*ARG_W +: ARG_W] = '0;
            end
        end
    end
    assign same = (r_fact_rd == q_fact);

    always_comb begin
        case (r_hstep)
            3'd0:    mix_v = 32'(r_pred);
            3'd1:    mix_v = 32'(r_neg);
            3'd2:    mix_v = 32'(r_cnt);
            3'd3:    mix_v = 32'(r_arg[0]);
            3'd4:    mix_v = 32'(r_arg[1]);
            default: mix_v = 32'(r_arg[2]);
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_HASH;
            S_HASH: begin
                if (invalid) n_state = S_OUT;
                else if (32'(r_hstep) == 32'(r_cnt) + 2) n_state = S_LOOK;
            end
            S_LOOK:   n_state = S_HEAD;
            S_HEAD:   n_state = S_FETCH;
            S_FETCH: begin
                if (!r_cur[ID_W] || r_steps > r_total) begin
                    n_state = (r_kind || r_total == TOT_W'(MAX_FACTS)) ? S_OUT : S_INSERT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP:    n_state = same ? S_OUT : S_FETCH;
            S_INSERT: n_state = S_OUT;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_W'(256);
            r_total <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + 1'b1;
            if (psel && penable && pwrite && paddr == REG_PRED_LIMIT) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
            if (r_state == S_INSERT) r_total <= r_total + 1'b1;
        end
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (clearing) head_mem[r_clr[BKT_W-1:0]] <= '0;
        else if (r_state == S_INSERT) head_mem[bkt] <= {1'b1, r_total[ID_W-1:0]};
        r_head_rd <= head_mem[bkt];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_INSERT) begin
            fact_mem[r_total[ID_W-1:0]] <= q_fact;
            link_mem[r_total[ID_W-1:0]] <= r_head;
        end
        r_fact_rd <= fact_mem[r_cur[ID_W-1:0]];
        r_link_rd <= link_mem[r_cur[ID_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= s_axis_tuser;
                r_pred   <= s_axis_tdata[7:0];
                r_neg    <= s_axis_tdata[8];
                r_cnt    <= s_axis_tdata[10:9];
                r_arg[0] <= s_axis_tdata[26:11];
                r_arg[1] <= s_axis_tdata[42:27];
                r_arg[2] <= s_axis_tdata[58:43];
                r_hash   <= FNV_BASIS;
                r_hstep  <= '0;
                r_steps  <= '0;
            end
            S_HASH: begin
                r_hash  <= (r_hash ^ mix_v) * FNV_PRIME;
                r_hstep <= r_hstep + 1'b1;
                r_id    <= '0;
                r_stat  <= ST_INVALID;
            end
            S_HEAD: begin
                r_cur  <= r_head_rd;
                r_head <= r_head_rd;
            end
            S_FETCH: begin
                r_id   <= '0;
                r_stat <= r_kind ? ST_NOT_FOUND : ST_FULL;
            end
            S_CMP: begin
                r_id    <= ID_OUT_W'(r_cur[ID_W-1:0]);
                r_stat  <= ST_FOUND;
                r_cur   <= r_link_rd;
                r_steps <= r_steps + 1'b1;
            end
            S_INSERT: begin
                r_id   <= ID_OUT_W'(r_total[ID_W-1:0]);
                r_stat <= ST_ADDED;
            end
            default: begin
            end
        endcase
    end
endmodule

/* design/fiht_checker.sv */
// ----------------------------------------------------------------------------
// fiht_assert
// port-level checks of the fact interning table
// ----------------------------------------------------------------------------
`include "fact_interning_hash_table_top_assert.svh"
module fiht_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import fiht_pkg::*;

    logic in_acc, no_id;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign no_id  = m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND ||
                    m_axis_tuser == ST_FULL || m_axis_tuser == ST_INVALID);

    `FIT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_acc, !s_axis_tready, "taken while busy")
    `FIT_ASSERT_IMP(a_no_take_with_result, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "taken")
    `FIT_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= ST_INVALID, "code")
    `FIT_ASSERT_IMP(a_zero_id, i_clk, i_rst_n, no_id, m_axis_tdata[9:0] == 10'd0, "failed with id")
endmodule

bind fact_interning_hash_table_top fiht_assert u_fiht_assert (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

/* dv/fiht_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fiht_checker
// watches the request and response streams and the register port, keeps its
// own copy of the interning table and compares every response word
// ----------------------------------------------------------------------------
module fiht_checker #(
    parameter int unsigned MAX_FACTS = 1024,
    parameter int unsigned BUCKETS   = 1024,
    parameter int unsigned MAX_PREDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tuser,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_seen
);
    import fiht_pkg::*;

    typedef struct packed {
        logic [PRED_W-1:0]  pred;
        logic               neg;
        logic [CNT_W-1:0]   cnt;
        logic [3*ARG_W-1:0] args;
    } t_fact;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [ID_OUT_W-1:0] id;
    } t_reply;

    // key of the fact (unused args zeroed) to its id
    int unsigned   id_of_fact[t_fact];
    int unsigned   stored_total;
    logic [8:0]    pred_limit;
    t_reply        replies_due[$];

    // w: kind[0], predicate[8:1], negated[9], arg_count[11:10], args[59:12]
    function automatic t_reply intern_fact(input logic [63:0] w);
        t_fact       f;
        int unsigned lim;
        t_reply      r;
        f.pred = w[8:1];
        f.neg  = w[9];
        f.cnt  = w[11:10];
        f.args = '0;
        if (f.cnt > 0) f.args[15:0]  = w[27:12];
        if (f.cnt > 1) f.args[31:16] = w[43:28];
        if (f.cnt > 2) f.args[47:32] = w[59:44];
        lim = (pred_limit < MAX_PREDS) ? pred_limit : MAX_PREDS;
        r.id = '0;
        if (f.pred >= lim || f.cnt > MAX_ARGS) begin
            r.status = ST_INVALID;
        end else if (id_of_fact.exists(f)) begin
            r.status = ST_FOUND;
            r.id     = ID_OUT_W'(id_of_fact[f]);
        end else if (w[0]) begin
            r.status = ST_NOT_FOUND;
        end else if (stored_total >= MAX_FACTS) begin
            r.status = ST_FULL;
        end else begin
            r.status = ST_ADDED;
            r.id     = ID_OUT_W'(stored_total);
            id_of_fact[f] = stored_total;
            stored_total++;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            id_of_fact.delete();
            replies_due.delete();
            stored_total = 0;
            pred_limit   = 9'd256;
            o_fail_count = 0;
            o_seen       = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_PRED_LIMIT)
                pred_limit = pwdata[8:0];
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(intern_fact({s_axis_tdata[62:0], s_axis_tuser}));
            if (m_axis_tvalid && m_axis_tready) begin
                got.id     = m_axis_tdata[ID_OUT_W-1:0];
                got.status = m_axis_tuser;
                o_seen++;
                if (replies_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected word: id %0d status %0d", got.id, got.status);
                end else begin
                    want = replies_due.pop_front();
                    if (want.id !== got.id || want.status !== got.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected id %0d status %0d, got id %0d status %0d",
                                     want.id, want.status, got.id, got.status);
                    end
                end
            end
        end
        o_pending = replies_due.size();
    end
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// random and directed add/find traffic into the fact interning table, with
// predicate limit changes between phases, random gaps and a long back-pressure
// ----------------------------------------------------------------------------
module tb;
    import fiht_pkg::*;

    localparam logic       KIND_ADD  = 1'b0;
    localparam logic       KIND_FIND = 1'b1;
    localparam int         LIMIT_CYCLES = 900000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    logic        s_axis_tuser;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    int          fail_count, pending, seen;
    int          cycles;
    bit          hold_off;
    int          sent;

    // pool of earlier facts so repeats and finds hit
    logic [63:0] history[$];

    fact_interning_hash_table_top dut (.*);

    fiht_checker chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("fact_interning_hash_table_top regression: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, and one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_PRED_LIMIT; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // w: kind[0], predicate[8:1], negated[9], arg_count[11:10], args[59:12]
    task automatic send_word(input logic [63:0] w, input bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w[0];
        s_axis_tdata  <= {5'd0, w[59:1]};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    function automatic logic [63:0] pack_req(input logic kind, input logic [7:0] pred,
                                             input logic neg, input logic [1:0] cnt,
                                             input logic [15:0] a0, input logic [15:0] a1,
                                             input logic [15:0] a2);
        return {4'd0, a2, a1, a0, cnt, neg, pred, kind};
    endfunction

    function automatic logic [63:0] random_req(input int pred_max);
        logic [63:0] w;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 && history.size() > 0) begin
            w = history[$urandom_range(0, history.size() - 1)];
            w[0] = 1'($urandom_range(0, 1));
            // junk in unused argument fields must not matter
            if (w[11:10] < 3) w[59:44] = 16'($urandom);
            if (w[11:10] < 2) w[43:28] = 16'($urandom);
        end else begin
            w = pack_req($urandom_range(0, 3) == 0, 8'($urandom_range(0, pred_max)),
                         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7)),
                         16'($urandom), 16'($urandom));
            if ($urandom_range(0, 29) == 0) w[8:1] = 8'($urandom);
            if (!w[0]) history.push_back(w);
        end
        return w;
    endfunction

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] w;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tuser = 1'b0; s_axis_tdata = '0;
        hold_off = 1'b0; sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // bucket clearing pass keeps tready low; handshakes absorb it

        // directed: extremes, finds before and after add, unused args
        send_word(pack_req(KIND_FIND, 8'd0, 1'b0, 2'd0, 16'd0, 16'd0, 16'd0), 0);
        send_word(pack_req(KIND_ADD, 8'd0, 1'b0, 2'd0, 16'hffff, 16'hffff, 16'hffff), 0);
        send_word(pack_req(KIND_ADD, 8'd0, 1'b0, 2'd0, 16'd0, 16'd1, 16'd2), 0);
        send_word(pack_req(KIND_FIND, 8'd0, 1'b0, 2'd0, 16'd5, 16'd5, 16'd5), 0);
        send_word(pack_req(KIND_ADD, 8'd0, 1'b1, 2'd0, 16'd0, 16'd0, 16'd0), 0);
        send_word(pack_req(KIND_ADD, 8'd255, 1'b1, 2'd3, 16'hffff, 16'hffff, 16'hffff), 0);
        send_word(pack_req(KIND_FIND, 8'd255, 1'b1, 2'd3, 16'hffff, 16'hffff, 16'hffff), 0);
        send_word(pack_req(KIND_FIND, 8'd255, 1'b1, 2'd3, 16'hffff, 16'hffff, 16'hfffe), 0);
        send_word(pack_req(KIND_ADD, 8'd7, 1'b0, 2'd1, 16'd9, 16'd1, 16'd1), 0);
        send_word(pack_req(KIND_ADD, 8'd7, 1'b0, 2'd1, 16'd9, 16'd2, 16'd3), 0);
        send_word(pack_req(KIND_ADD, 8'd7, 1'b0, 2'd2, 16'd9, 16'd2, 16'd3), 0);
        send_word(pack_req(KIND_FIND, 8'd7, 1'b0, 2'd2, 16'd9, 16'd2, 16'hffff), 0);
        send_word(pack_req(KIND_ADD, 8'haa, 1'b0, 2'd3, 16'h5555, 16'haaaa, 16'h5555), 0);
        send_word(pack_req(KIND_ADD, 8'h55, 1'b1, 2'd2, 16'haaaa, 16'h5555, 16'haaaa), 0);
        drain();

        // predicate limit zero: everything invalid
        reg_write(32'd0);
        send_word(pack_req(KIND_ADD, 8'd0, 1'b0, 2'd0, 16'd0, 16'd0, 16'd0), 0);
        send_word(pack_req(KIND_FIND, 8'd0, 1'b0, 2'd0, 16'd0, 16'd0, 16'd0), 0);
        drain();
        // limit one, then just below and at the boundary
        reg_write(32'd1);
        send_word(pack_req(KIND_ADD, 8'd1, 1'b0, 2'd0, 16'd0, 16'd0, 16'd0), 0);
        send_word(pack_req(KIND_FIND, 8'd0, 1'b0, 2'd0, 16'd0, 16'd0, 16'd0), 0);
        drain();
        reg_write(32'd100);
        send_word(pack_req(KIND_ADD, 8'd99, 1'b0, 2'd1, 16'd1, 16'd0, 16'd0), 0);
        send_word(pack_req(KIND_ADD, 8'd100, 1'b0, 2'd1, 16'd1, 16'd0, 16'd0), 0);
        drain();
        // above MAX_PREDS behaves as MAX_PREDS
        reg_write(32'h1ff);

        // random phases under several limits, with a long stall in the middle
        for (int ph = 0; ph < 4; ph++) begin
            int pmax;
            pmax = (ph == 2) ? 30 : 255;
            for (int n = 0; n < 100; n++) begin
                if (ph == 1 && n == 10) begin
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (600) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                w = random_req(pmax);
                send_word(w, (n % 80) >= 20);
            end
            drain();
            case (ph)
                0: reg_write(32'd256);
                1: reg_write(32'd20);
                2: reg_write(32'd255);
                default: ;
            endcase
        end

        // fill to capacity and beyond to hit the full table
        reg_write(32'd256);
        while (chk.stored_total < 1024 + 8) begin
            send_word(pack_req(KIND_ADD, 8'($urandom), 1'($urandom), 2'd3, 16'($urandom),
                               16'($urandom), 16'($urandom)), 0);
            if (sent > 4000) break;
            if (chk.stored_total >= 1024) begin
                repeat (8) send_word(pack_req(KIND_ADD, 8'd3, 1'b1, 2'd3, 16'($urandom),
                                              16'($urandom), 16'($urandom)), 0);
                break;
            end
        end
        // finds still resolve on a full table
        for (int n = 0; n < 20; n++) send_word(random_req(255), 1);
        drain();

        $display("%0d request words sent, %0d response words checked", sent, seen);
        $display("covered add/find, invalid predicates and limits 0..511, full table, long stall");
        if (fail_count == 0 && pending == 0)
            $display("fact_interning_hash_table_top regression: pass");
        else
            $display("fact_interning_hash_table_top regression: fail");
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/fiht_pkg.sv
design/fact_interning_hash_table_top.sv
design/fiht_checker.sv
dv/fiht_checker.sv
dv/tb.sv
